/* src/masked_byte_pattern_search_top_defines.svh */
// assertion macros shared by the masked byte pattern search rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef MASKED_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MBPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MBPS_ASSERT_NOW(label, ante, cons, msg)
`define MBPS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* src/mbps_pkg.sv */
// types and constants for the masked byte pattern search
// no dependencies
`default_nettype none

package mbps_pkg;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 6;
    localparam int ADDR_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_0   = 4'd0,
        REG_PATTERN_1   = 4'd1,
        REG_PATTERN_2   = 4'd2,
        REG_PATTERN_3   = 4'd3,
        REG_CARE_MASK   = 4'd4,
        REG_PATTERN_LEN = 4'd5,
        REG_BASE_ADDR   = 4'd6,
        REG_REPORT_REL  = 4'd7
    } cfg_reg_idx_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [3:0][CFG_DATA_W-1:0] pattern_word;
        logic [31:0]                care_mask;
        logic [LEN_W-1:0]           pattern_length;
        logic [ADDR_W-1:0]          base_address;
        logic                       report_relative;
    } cfg_t;

    // one entry of the result queue
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] offset;
    } result_t;

endpackage

`default_nettype wire

/* src/mbps_cfg_regs.sv */
// configuration register file of the pattern search
// depends on mbps_pkg
`default_nettype none

module mbps_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
    output mbps_pkg::cfg_t                    cfg
);
    import mbps_pkg::*;

    // everything clears except the length, which starts at one
    localparam cfg_t CFG_RESET = '{
        pattern_word:    '0,
        care_mask:       '0,
        pattern_length:  LEN_W'(1),
        base_address:    '0,
        report_relative: 1'b0
    };

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_0:   cfg_next.pattern_word[0] = cfg_data;
                REG_PATTERN_1:   cfg_next.pattern_word[1] = cfg_data;
                REG_PATTERN_2:   cfg_next.pattern_word[2] = cfg_data;
                REG_PATTERN_3:   cfg_next.pattern_word[3] = cfg_data;
                REG_CARE_MASK:   cfg_next.care_mask = cfg_data[31:0];
                REG_PATTERN_LEN: cfg_next.pattern_length = cfg_data[LEN_W-1:0];
                REG_BASE_ADDR:   cfg_next.base_address = cfg_data[ADDR_W-1:0];
                REG_REPORT_REL:  cfg_next.report_relative = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/mbps_front.sv */
// front end: byte window, scan counter, masked compare, result decision
// depends on mbps_pkg and the assertion macro header
`default_nettype none
`include "masked_byte_pattern_search_top_defines.svh"

module mbps_front #(
    parameter int MAX_PATTERN = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mbps_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [7:0]      data_byte,
    input  wire logic            last_byte,
    input  wire logic            q_full,
    output logic                 q_push,
    output mbps_pkg::result_t    q_data
);
    import mbps_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [MAX_PATTERN-1:0][7:0] win_reg;
    logic [MAX_PATTERN-1:0][7:0] win_next;
    logic [ADDR_W-1:0]           seen_reg;
    logic [ADDR_W-1:0]           seen_next;
    logic                        latched_reg;
    logic                        latched_next;

    logic [LEN_W-1:0]            eff_len;
    logic [MAX_PATTERN-1:0][7:0] align_pat;
    logic [MAX_PATTERN-1:0]      align_care;
    logic [MAX_PATTERN-1:0]      pos_ok;
    logic [LEN_W-1:0]            k_idx;
    logic [ADDR_W-1:0]           seen_inc;
    logic                        enough;
    logic                        hit;
    logic                        accept;
    logic                        emit_found;
    logic                        emit_miss;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // clamp the programmed length into 1..MAX_PATTERN
    always_comb
    begin
        if (cfg.pattern_length == '0)
            eff_len = LEN_W'(1);
        else if (cfg.pattern_length > MAX_LEN)
            eff_len = MAX_LEN;
        else
            eff_len = cfg.pattern_length;
    end

    // line the pattern up with window age: position j holds pattern byte len-1-j
    always_comb
    begin
        k_idx = '0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            k_idx = eff_len - LEN_W'(1) - LEN_W'(j);
            align_pat[j]  = cfg.pattern_word[k_idx[4:3]][k_idx[2:0]*8 +: 8];
            align_care[j] = (LEN_W'(j) < eff_len) && cfg.care_mask[k_idx[4:0]];
        end
    end

    // shift the new byte in at the young end
    always_comb
    begin
        win_next[0] = data_byte;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            win_next[j] = win_reg[j-1];
        end
    end

    // masked compare against the shifted window
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            pos_ok[j] = !align_care[j] || (win_next[j] == align_pat[j]);
        end
    end

    assign hit      = &pos_ok;
    assign seen_inc = (&seen_reg) ? seen_reg : seen_reg + ADDR_W'(1);
    assign enough   = seen_inc >= ADDR_W'(eff_len);

    // result decision
    assign emit_found = !latched_reg && enough && hit;
    assign emit_miss  = last_byte && !latched_reg && !emit_found;

    assign q_push        = accept && (emit_found || emit_miss);
    assign q_data.found  = emit_found;
    assign q_data.offset = emit_found ? seen_inc - ADDR_W'(eff_len) : '0;

    // scan state update, final byte restarts the scan
    always_comb
    begin
        seen_next    = seen_reg;
        latched_next = latched_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                seen_next    = '0;
                latched_next = 1'b0;
            end
            else
            begin
                seen_next    = seen_inc;
                latched_next = latched_reg || emit_found;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            latched_reg <= 1'b0;
        end
        else
        begin
            seen_reg    <= seen_next;
            latched_reg <= latched_next;
        end
    end

    // window takes only accepted bytes; stale bytes from an earlier scan never decide a result
    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

    `MBPS_ASSERT_NOW(a_miss_only_on_last, q_push && !q_data.found, last_byte, "miss result without final byte")
    `MBPS_ASSERT_NOW(a_single_result, accept && latched_reg && !last_byte, !q_push, "second result in one scan")
    `MBPS_ASSERT_NEXT(a_latch_after_found, q_push && q_data.found && !last_byte, latched_reg, "match not latched")

endmodule

`default_nettype wire

/* src/mbps_queue.sv */
// short result queue between front and back end
// depends on mbps_pkg and the assertion macro header
`default_nettype none
`include "masked_byte_pattern_search_top_defines.svh"

module mbps_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mbps_pkg::result_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output mbps_pkg::result_t      pop_data,
    output logic                   not_empty
);
    import mbps_pkg::*;

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `MBPS_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
    `MBPS_ASSERT_NOW(a_no_pop_empty, pop, not_empty, "pop from empty queue")
    `MBPS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

`default_nettype wire

/* src/mbps_back.sv */
// back end: address formation and output register
// depends on mbps_pkg
`default_nettype none

module mbps_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mbps_pkg::cfg_t              cfg,
    input  wire logic                        q_not_empty,
    input  wire mbps_pkg::result_t           q_data,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             found,
    output logic [mbps_pkg::ADDR_W-1:0]      match_address
);
    import mbps_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic              found_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_calc;

    // load when the output register is empty or being taken
    assign q_pop = q_not_empty && (!valid_reg || !out_stall);

    // absolute or base-relative address, zero for a miss
    always_comb
    begin
        if (!q_data.found || cfg.report_relative)
            addr_calc = q_data.offset;
        else
            addr_calc = cfg.base_address + q_data.offset;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            found_reg <= q_data.found;
            addr_reg  <= addr_calc;
        end
    end

    assign out_valid     = valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

endmodule

`default_nettype wire

/* src/masked_byte_pattern_search_top.sv */
// Masked byte pattern search, top level.
// Input channel (in_valid, in_stall, data_byte, last_byte) takes one byte of
// the scanned range per request; last_byte marks the end of a scan.
// Output channel (out_valid, out_stall, found, match_address) carries at most
// one request per scan: the first match, or a miss on the final byte.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it while no byte is in flight, the block does not enforce this.
// Throughput: one byte per cycle while in_stall is low; the masked window
// compare in the front end is combinational.
// A result is written into the result queue and then loaded into the output
// register, where it is shown; out_stall can hold it in either.
// Stall: results wait in a two-entry queue plus the output register; the
// input side raises in_stall only when that queue is full.
// Reset: configuration registers return to their reset values, the scan state
// clears and no result is pending.
// depends on mbps_pkg, mbps_cfg_regs, mbps_front, mbps_queue, mbps_back
`default_nettype none

module masked_byte_pattern_search_top #(
    parameter int MAX_PATTERN = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            last_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 found,
    output logic [mbps_pkg::ADDR_W-1:0]          match_address
);
    import mbps_pkg::*;

    cfg_t    cfg;
    result_t push_data;
    result_t pop_data;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_not_empty;

    // configuration registers
    mbps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // window, counter and match decision
    mbps_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    // result queue
    mbps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty)
    );

    // address formation and output register
    mbps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_not_empty   (q_not_empty),
        .q_data        (pop_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_address (match_address)
    );

endmodule

`default_nettype wire
